// ===== design/tcc_pkg.sv =====
`timescale 1ns / 1ps

package tcc_pkg;

  // Screen geometry and tab width defaults
  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int TAB_SPACES     = 4;

  // Fixed field widths
  localparam int SYM_W  = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ATTR_W = 8;
  // Counts up to the largest tab width
  localparam int LEFT_W = 4;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  // Character codes
  localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;
  localparam logic [SYM_W-1:0] CH_BS    = 8'h08;
  localparam logic [SYM_W-1:0] CH_TAB   = 8'h09;
  localparam logic [SYM_W-1:0] CH_LF    = 8'h0A;
  localparam logic [SYM_W-1:0] CH_CR    = 8'h0D;
  localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;

  // Result kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_BS,
    OP_LF,
    OP_CR
  } op_t;

  // One character in flight
  typedef struct packed {
    op_t               op;
    logic [SYM_W-1:0]  glyph;
    logic [LEFT_W-1:0] left;
    logic              clear;
  } work_t;

  // One result word
  typedef struct packed {
    logic              kind;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic [ATTR_W-1:0] attribute;
    logic [SYM_W-1:0]  glyph;
    logic              last;
  } res_t;

endpackage

// ===== design/tcc_decode.sv =====
`timescale 1ns / 1ps

module tcc_decode #(
  parameter int TabSpaces = tcc_pkg::TAB_SPACES
) (
  input  logic [tcc_pkg::SYM_W-1:0] symbol,
  output logic                      keep,
  output tcc_pkg::work_t            work
);
  import tcc_pkg::*;

  always_comb begin
    keep       = (symbol != CH_NUL);
    work.op    = OP_WRITE;
    work.glyph = symbol;
    work.left  = LEFT_W'(1);
    work.clear = 1'b0;
    case (symbol)
      CH_BS: begin
        work.op    = OP_BS;
        work.glyph = CH_SPACE;
      end
      CH_TAB: begin
        work.glyph = CH_SPACE;
        work.left  = LEFT_W'(TabSpaces);
      end
      CH_LF:   work.op = OP_LF;
      CH_CR:   work.op = OP_CR;
      default: work.op = OP_WRITE;
    endcase
  end

endmodule

// ===== design/tcc_step.sv =====
`timescale 1ns / 1ps

module tcc_step #(
  parameter int ScreenColumns = tcc_pkg::SCREEN_COLUMNS,
  parameter int ScreenRows    = tcc_pkg::SCREEN_ROWS
) (
  input  tcc_pkg::work_t             work,
  input  logic [tcc_pkg::COL_W-1:0]  col,
  input  logic [tcc_pkg::ROW_W-1:0]  row,
  input  logic [tcc_pkg::ATTR_W-1:0] attr,
  output tcc_pkg::work_t             work_nxt,
  output logic [tcc_pkg::COL_W-1:0]  col_nxt,
  output logic [tcc_pkg::ROW_W-1:0]  row_nxt,
  output logic                       emit,
  output logic                       final_step,
  output tcc_pkg::res_t              res
);
  import tcc_pkg::*;

  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic              col_wrap;
  logic              row_wrap;
  logic [LEFT_W-1:0] left_m;

  assign col_inc  = {1'b0, col} + (COL_W+1)'(1);
  assign row_inc  = {1'b0, row} + (ROW_W+1)'(1);
  assign col_wrap = (col_inc >= (COL_W+1)'(ScreenColumns));
  assign row_wrap = (row_inc >= (ROW_W+1)'(ScreenRows));
  assign left_m   = work.left - LEFT_W'(1);

  always_comb begin
    work_nxt = work;
    col_nxt  = col;
    row_nxt  = row;
    emit     = 1'b0;
    res      = '0;
    if (work.clear) begin
      // pending clear after a wrap off the bottom row
      emit           = 1'b1;
      res.kind       = KIND_CLEAR;
      res.last       = (work.left == '0);
      col_nxt        = '0;
      row_nxt        = '0;
      work_nxt.clear = 1'b0;
    end else begin
      case (work.op)
        OP_WRITE: begin
          emit          = 1'b1;
          res.kind      = KIND_WRITE;
          res.column    = col;
          res.row       = row;
          res.attribute = attr;
          res.glyph     = work.glyph;
          work_nxt.left = left_m;
          if (col_wrap) begin
            col_nxt = '0;
            if (row_wrap) begin
              row_nxt        = '0;
              work_nxt.clear = 1'b1;
            end else begin
              row_nxt = row_inc[ROW_W-1:0];
            end
          end else begin
            col_nxt = col_inc[COL_W-1:0];
          end
          res.last = (left_m == '0) && !(col_wrap && row_wrap);
        end
        OP_BS: begin
          if (col != '0) begin
            emit          = 1'b1;
            col_nxt       = col - COL_W'(1);
            res.kind      = KIND_WRITE;
            res.column    = col - COL_W'(1);
            res.row       = row;
            res.attribute = attr;
            res.glyph     = work.glyph;
            res.last      = 1'b1;
          end
        end
        OP_LF: begin
          col_nxt = '0;
          if (row_wrap) begin
            emit     = 1'b1;
            res.kind = KIND_CLEAR;
            res.last = 1'b1;
            row_nxt  = '0;
          end else begin
            row_nxt = row_inc[ROW_W-1:0];
          end
        end
        OP_CR:   col_nxt = '0;
        default: col_nxt = col;
      endcase
    end
    final_step = emit ? res.last : 1'b1;
  end

endmodule

// ===== design/text_console_cursor_engine.sv =====
// Path: an accepted character word is held in the work register, and its first result word is
//   registered in the output register, which drives out_valid.
// Throughput: one character per cycle while out_stall is low and each causes at most one result;
//   one causing more holds the input, one result per cycle (out_stall permitting), until its last.
// Reset (rst_n, synchronous, active low): cursor to (0, 0), attribute to 7, pipeline empty.
`timescale 1ns / 1ps

module text_console_cursor_engine #(
  parameter int ScreenColumns = tcc_pkg::SCREEN_COLUMNS,
  parameter int ScreenRows    = tcc_pkg::SCREEN_ROWS,
  parameter int TabSpaces     = tcc_pkg::TAB_SPACES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [tcc_pkg::SYM_W-1:0]  in_symbol,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_kind,
  output logic [tcc_pkg::COL_W-1:0]  out_column,
  output logic [tcc_pkg::ROW_W-1:0]  out_row,
  output logic [tcc_pkg::ATTR_W-1:0] out_attribute,
  output logic [tcc_pkg::SYM_W-1:0]  out_glyph,
  output logic                       out_last,
  input  logic                       cfg_wr_en,
  input  logic [tcc_pkg::ATTR_W-1:0] cfg_wr_data
);
  import tcc_pkg::*;

  // Work register: the character being turned into results
  logic              wk_valid_r;
  logic              wk_valid_nxt;
  work_t             wk_r;
  work_t             wk_nxt;

  // Cursor and attribute
  logic [COL_W-1:0]  cur_col_r;
  logic [COL_W-1:0]  cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r;
  logic [ROW_W-1:0]  cur_row_nxt;
  logic [ATTR_W-1:0] attr_r;

  // Output register
  logic              out_valid_r;
  res_t              res_r;

  // Decode and step results
  logic              dec_keep;
  work_t             dec_work;
  work_t             stp_work;
  logic [COL_W-1:0]  stp_col;
  logic [ROW_W-1:0]  stp_row;
  logic              stp_emit;
  logic              stp_final;
  res_t              stp_res;

  logic              out_free;
  logic              go;
  logic              in_acc;

  tcc_decode #(
    .TabSpaces (TabSpaces)
  ) u_decode (
    .symbol (in_symbol),
    .keep   (dec_keep),
    .work   (dec_work)
  );

  tcc_step #(
    .ScreenColumns (ScreenColumns),
    .ScreenRows    (ScreenRows)
  ) u_step (
    .work       (wk_r),
    .col        (cur_col_r),
    .row        (cur_row_r),
    .attr       (attr_r),
    .work_nxt   (stp_work),
    .col_nxt    (stp_col),
    .row_nxt    (stp_row),
    .emit       (stp_emit),
    .final_step (stp_final),
    .res        (stp_res)
  );

  // Advance the step only when the output register can take a word this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign go       = wk_valid_r && out_free;

  // Take a new character when the work register is empty or empties this cycle
  assign in_stall = wk_valid_r && !(go && stp_final);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    wk_valid_nxt = wk_valid_r;
    wk_nxt       = wk_r;
    cur_col_nxt  = cur_col_r;
    cur_row_nxt  = cur_row_r;
    if (go) begin
      cur_col_nxt = stp_col;
      cur_row_nxt = stp_row;
      wk_nxt      = stp_work;
      if (stp_final) begin
        wk_valid_nxt = 1'b0;
      end
    end
    if (in_acc) begin
      // drop NUL here: it never occupies the work register
      wk_valid_nxt = dec_keep;
      wk_nxt       = dec_work;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wk_valid_r  <= 1'b0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      attr_r      <= ATTR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      wk_valid_r <= wk_valid_nxt;
      cur_col_r  <= cur_col_nxt;
      cur_row_r  <= cur_row_nxt;
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
      if (go && stp_emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    wk_r <= wk_nxt;
    if (go && stp_emit) begin
      res_r <= stp_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = res_r.kind;
  assign out_column    = res_r.column;
  assign out_row       = res_r.row;
  assign out_attribute = res_r.attribute;
  assign out_glyph     = res_r.glyph;
  assign out_last      = res_r.last;

`ifndef NO_ASSERTIONS
  // Cursor stays on the screen
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_col_r < COL_W'(ScreenColumns)) && (cur_row_r < ROW_W'(ScreenRows)))
    else $error("cursor left the screen");

  // A clear word carries zero position, attribute and glyph
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_CLEAR) |->
      (out_column == '0 && out_row == '0 && out_attribute == '0 && out_glyph == '0))
    else $error("clear word with non-zero fields");

  // A pending clear with tab spaces still to follow holds the input until they are done
  a_clear_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (wk_valid_r && wk_r.clear && (wk_r.left != '0)) |-> in_stall)
    else $error("new character taken while a clear is pending");

  // A final result word from the step is registered and presented with out_last set
  a_last_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (go && stp_emit && stp_res.last) |=> (out_valid && out_last))
    else $error("final word not presented");
`endif

endmodule
